// File: hdl/reactivity_to_probability_converter_macros.svh
// assertion macros shared by the converter
`ifndef REACTIVITY_TO_PROBABILITY_CONVERTER_MACROS_SVH
`define REACTIVITY_TO_PROBABILITY_CONVERTER_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define RPC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define RPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// File: hdl/rpc_pkg.sv
// ----------------------------------------------------------------------------
// rpc_pkg
// shared types, codes and constants of the reactivity converter
// ----------------------------------------------------------------------------
package rpc_pkg;
	localparam int VW = 24;
	localparam logic signed [VW-1:0] Q_ONE = 24'sd65536;

	typedef enum logic [2:0] {
		MODE_SKIP   = 3'd0,
		MODE_MAP    = 3'd1,
		MODE_CUTOFF = 3'd2,
		MODE_LINEAR = 3'd3,
		MODE_LOGLIN = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		REG_MODE      = 3'd0,
		REG_CUTOFF    = 3'd1,
		REG_SLOPE     = 3'd2,
		REG_INTERCEPT = 3'd3,
		REG_MISSING   = 3'd4
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_LOGNORM,
		ST_LOGSQ,
		ST_LOGMUL,
		ST_DIVSET,
		ST_DIV,
		ST_DONE
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture_in;   // latch input and read store
		logic eval;         // decide direct result or start arithmetic
		logic log_norm;     // normalize log operand
		logic log_sq;       // one squaring step
		logic log_mul;      // scale by ln2
		logic div_set;      // load divider
		logic div_step;     // one divider bit
		logic finish;       // write result to output
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic need_log;
		logic need_div;
		logic log_last;
		logic div_last;
	} stat_t;

	// map segment breakpoints and targets
	function automatic logic signed [VW-1:0] map_src(input logic [1:0] j);
		case (j)
			2'd0: map_src = 24'sd16384;
			2'd1: map_src = 24'sd19661;
			default: map_src = 24'sd45875;
		endcase
	endfunction

	function automatic logic signed [VW-1:0] map_tgt(input logic [1:0] j);
		case (j)
			2'd0: map_tgt = 24'sd22938;
			2'd1: map_tgt = 24'sd36045;
			2'd2: map_tgt = 24'sd55706;
			default: map_tgt = 24'sd65536;
		endcase
	endfunction
endpackage

// File: hdl/reactivity_to_probability_converter.sv
// ----------------------------------------------------------------------------
// reactivity_to_probability_converter
// stores a batch of reactivities and returns converted values on fetch
// ----------------------------------------------------------------------------
//  channel  handshake                  payload
//  cfg      cfg_valid / cfg_ready      cfg_index, cfg_data
//  in       in_valid / in_ready        action, sample_value, final_sample
//  out      out_valid / out_ready      converted_value, is_last, mode_ok,
//                                      not_ready, overflowed
// a load is taken whenever no fetch is in progress; a fetch reads the store and
// may compute a log (16 squarings) and may then run a 42-step serial divide
// the serial divider and log squaring unit set the fetch time
// no reset sweep: the store is read only at written addresses
// a finished result waits in the output register while the next load is taken
`include "reactivity_to_probability_converter_macros.svh"
module reactivity_to_probability_converter import rpc_pkg::*; #(
	parameter int STORE_DEPTH = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [VW-1:0]        cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 action,
	input  logic signed [VW-1:0] sample_value,
	input  logic                 final_sample,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [VW-1:0] converted_value,
	output logic                 is_last,
	output logic                 mode_ok,
	output logic                 not_ready,
	output logic                 overflowed
);
	logic [2:0]           mode_q;
	logic signed [VW-1:0] cutoff_q, slope_q, icpt_q, missing_q;
	logic                 busy, start, load_en, out_free;
	cmd_t                 cmd;
	stat_t                stat;

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SKIP;
			cutoff_q <= 24'sd16384;
			slope_q <= 24'sd44564;
			icpt_q <= 24'sd13107;
			missing_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MODE:      mode_q <= cfg_data[2:0];
				REG_CUTOFF:    cutoff_q <= cfg_data;
				REG_SLOPE:     slope_q <= cfg_data;
				REG_INTERCEPT: icpt_q <= cfg_data;
				REG_MISSING:   missing_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input transfer steering
	assign in_ready = !busy;
	assign load_en = in_valid && in_ready && !action;
	assign start = in_valid && in_ready && action;
	assign out_free = !out_valid || out_ready;

	rpc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .out_free(out_free),
		.stat(stat), .busy(busy), .cmd(cmd)
	);

	rpc_datapath #(.STORE_DEPTH(STORE_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .load_en(load_en), .sample_value(sample_value),
		.final_sample(final_sample), .mode(mode_q), .cutoff(cutoff_q),
		.slope(slope_q), .icpt(icpt_q), .missing(missing_q), .cmd(cmd),
		.out_take(out_valid && out_ready), .stat(stat), .out_valid(out_valid),
		.converted_value(converted_value), .is_last(is_last), .mode_ok(mode_ok),
		.not_ready(not_ready), .overflowed(overflowed)
	);

	// checks
	`RPC_ASSERT_IMP(a_no_load_busy, clk, arst_n, busy, !load_en)
	`RPC_ASSERT_NEXT(a_finish_valid, clk, arst_n, cmd.finish, out_valid)
	`RPC_ASSERT_IMP(a_nr_no_last, clk, arst_n, out_valid && not_ready, !is_last)
endmodule

// File: hdl/rpc_ram.sv
// ----------------------------------------------------------------------------
// rpc_ram
// generic single-port write, single read ram with registered read data
// ----------------------------------------------------------------------------
module rpc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: hdl/rpc_ctrl.sv
// ----------------------------------------------------------------------------
// rpc_ctrl
// sequencer for one fetch: store read, optional log, optional serial divide
// ----------------------------------------------------------------------------
module rpc_ctrl import rpc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  logic  out_free,
	input  stat_t stat,
	output logic  busy,
	output cmd_t  cmd
);
	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.capture_in = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_READ: state_d = ST_EVAL;
			// divide need is known only once eval has registered it
			ST_EVAL: begin
				cmd.eval = 1'b1;
				if (stat.need_log) state_d = ST_LOGNORM;
				else state_d = ST_DIVSET;
			end
			ST_LOGNORM: begin
				cmd.log_norm = 1'b1;
				state_d = ST_LOGSQ;
			end
			ST_LOGSQ: begin
				cmd.log_sq = 1'b1;
				if (stat.log_last) state_d = ST_LOGMUL;
			end
			ST_LOGMUL: begin
				cmd.log_mul = 1'b1;
				state_d = ST_DIVSET;
			end
			ST_DIVSET: begin
				cmd.div_set = 1'b1;
				if (stat.need_div) state_d = ST_DIV;
				else state_d = ST_DONE;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

// File: hdl/rpc_datapath.sv
// ----------------------------------------------------------------------------
// rpc_datapath
// sample store, batch bookkeeping, conversion arithmetic and output register
// ----------------------------------------------------------------------------
module rpc_datapath import rpc_pkg::*; #(
	parameter int STORE_DEPTH = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load_en,
	input  logic signed [VW-1:0] sample_value,
	input  logic                 final_sample,
	input  logic [2:0]           mode,
	input  logic signed [VW-1:0] cutoff,
	input  logic signed [VW-1:0] slope,
	input  logic signed [VW-1:0] icpt,
	input  logic signed [VW-1:0] missing,
	input  cmd_t                 cmd,
	input  logic                 out_take,
	output stat_t                stat,
	output logic                 out_valid,
	output logic signed [VW-1:0] converted_value,
	output logic                 is_last,
	output logic                 mode_ok,
	output logic                 not_ready,
	output logic                 overflowed
);
	localparam int AW = $clog2(STORE_DEPTH);
	localparam int CW = $clog2(STORE_DEPTH + 1);

	logic [CW-1:0]         count_q, pos_q;
	logic signed [VW-1:0]  max_q;
	logic                  complete_q, ovf_q;
	logic [VW-1:0]         rdata;
	logic                  avail_q, last_q;
	logic signed [VW-1:0]  res_q, v;
	logic signed [VW-1:0]  rep;
	logic [CW-1:0]         cnt_eff;
	logic                  fresh, store_we;

	// sample store
	assign fresh = complete_q;
	assign cnt_eff = fresh ? '0 : count_q;
	assign store_we = load_en && (cnt_eff < CW'(STORE_DEPTH));
	rpc_ram #(.WIDTH(VW), .DEPTH(STORE_DEPTH)) u_ram (
		.clk(clk), .we(store_we), .waddr(cnt_eff[AW-1:0]), .wdata(sample_value),
		.raddr(pos_q[AW-1:0]), .rdata(rdata)
	);
	assign v = $signed(rdata);
	assign rep = sample_value[VW-1] ? missing : sample_value;

	// batch bookkeeping, read position held until the result is issued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pos_q <= '0;
			max_q <= '0;
			complete_q <= 1'b0;
			ovf_q <= 1'b0;
			avail_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			if (load_en) begin
				if (fresh) begin
					pos_q <= '0;
					ovf_q <= 1'b0;
				end
				if (store_we) begin
					if (cnt_eff == '0 || rep > (fresh ? 24'sd0 : max_q)) max_q <= rep;
					else if (fresh) max_q <= '0;
					count_q <= cnt_eff + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
				complete_q <= final_sample;
			end
			if (cmd.capture_in) begin
				avail_q <= complete_q && (pos_q < count_q);
				last_q <= (pos_q + 1'b1) == count_q;
			end
			if (cmd.finish && avail_q) pos_q <= pos_q + 1'b1;
		end
	end

	// arithmetic state
	logic signed [25:0] num_q;      // numerator x - intercept
	logic [22:0]        ux_q;
	logic [4:0]         p_q;
	logic [31:0]        y_q;
	logic [15:0]        frac_q;
	logic [4:0]         it_q;
	logic signed [VW-1:0] lnv_q;
	logic [41:0]        rem_q;
	logic [41:0]        quo_q;
	logic [40:0]        dvs_q;
	logic [5:0]         dcnt_q;
	logic               div_on_q;
	logic               lin_m, log_m;
	logic [63:0]        sq;
	logic [4:0]         pn;
	logic [1:0]         seg;
	logic signed [VW-1:0] ls, lt, src, tgt;
	logic signed [VW:0] dx, dd;
	logic signed [VW:0] dt;
	logic [48:0]        mapnum;
	logic [VW:0]        mapden;
	logic               map_neg;
	logic               map_hit;

	assign lin_m = mode == MODE_LINEAR;
	assign log_m = mode == MODE_LOGLIN;

	// priority encode of log operand
	always_comb begin
		pn = '0;
		for (int i = 1; i < 23; i++) begin
			if (ux_q[i]) pn = 5'(i);
		end
	end
	assign sq = {32'd0, y_q} * {32'd0, y_q};

	// map segment select
	always_comb begin
		seg = 2'd3;
		map_hit = 1'b1;
		if (v <= map_src(2'd0)) seg = 2'd0;
		else if (v <= map_src(2'd1)) seg = 2'd1;
		else if (v <= map_src(2'd2)) seg = 2'd2;
		else if (v > max_q) map_hit = 1'b0;
		ls = (seg == 2'd0) ? 24'sd0 : map_src(seg - 2'd1);
		lt = (seg == 2'd0) ? 24'sd0 : map_tgt(seg - 2'd1);
		src = (seg == 2'd3) ? max_q : map_src(seg);
		tgt = map_tgt(seg);
		dx = {v[VW-1], v} - {ls[VW-1], ls};
		dt = {tgt[VW-1], tgt} - {lt[VW-1], lt};
		dd = {src[VW-1], src} - {ls[VW-1], ls};
		map_neg = dt[VW];
		mapnum = 49'(dx[VW-1:0]) * 49'(map_neg ? -dt : dt);
		mapden = dd[VW:0];
	end

	// divider operand selection
	logic [41:0] div_num;
	logic [40:0] div_den;
	logic        div_need;
	logic signed [25:0] ln_num;
	assign ln_num = {{2{lnv_q[VW-1]}}, lnv_q} - {{2{icpt[VW-1]}}, icpt};

	always_comb begin
		div_num = '0;
		div_den = '0;
		div_need = 1'b0;
		if (mode == MODE_MAP) begin
			div_num = 42'(mapnum);
			div_den = 41'(mapden);
			div_need = map_hit;
		end else begin
			div_num = {(num_q[25] ? 26'(-num_q) : 26'(num_q)), 16'd0};
			div_den = {17'd0, (slope[VW-1] ? 24'(-slope) : 24'(slope))};
			div_need = (num_q != '0) && (slope != '0) && (num_q[25] == slope[VW-1]);
		end
	end

	// status to controller
	assign stat.need_log = avail_q && log_m && !v[VW-1] && (v != '0);
	assign stat.need_div = div_on_q;
	assign stat.log_last = it_q == 5'd15;
	assign stat.div_last = dcnt_q == 6'd0;

	// log2 as integer and fraction, then scaled by ln2
	logic [55:0] lnprod;
	logic signed [22:0] l2;
	logic [21:0] l2mag;
	assign l2 = 23'($signed({1'b0, p_q, frac_q})) - 23'sd1048576;
	assign l2mag = l2[22] ? 22'(-l2) : 22'(l2);
	assign lnprod = 56'(l2mag) * 56'd2977044472 + 56'h80000000;

	// datapath registers
	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			num_q <= {{2{v[VW-1]}}, v} - {{2{icpt[VW-1]}}, icpt};
			ux_q <= v[22:0];
			if (!avail_q) begin
				res_q <= '0;
				div_on_q <= 1'b0;
			end else if (mode == MODE_SKIP) begin
				res_q <= v;
				div_on_q <= 1'b0;
			end else if (v[VW-1]) begin
				res_q <= missing;
				div_on_q <= 1'b0;
			end else begin
				case (mode)
					MODE_MAP: begin
						if (v == '0) begin
							res_q <= '0;
							div_on_q <= 1'b0;
						end else if (!map_hit) begin
							res_q <= v;
							div_on_q <= 1'b0;
						end else begin
							res_q <= lt;
							div_on_q <= 1'b1;
						end
					end
					MODE_CUTOFF: begin
						res_q <= (v < cutoff) ? 24'sd0 : Q_ONE;
						div_on_q <= 1'b0;
					end
					MODE_LINEAR: begin
						res_q <= '0;
						div_on_q <= 1'b1;
					end
					MODE_LOGLIN: begin
						res_q <= '0;
						div_on_q <= 1'b0;
					end
					default: begin
						res_q <= v;
						div_on_q <= 1'b0;
					end
				endcase
			end
		end
		if (cmd.log_norm) begin
			p_q <= pn;
			y_q <= 32'({ux_q, 30'd0} >> pn);
			frac_q <= '0;
			it_q <= '0;
		end
		if (cmd.log_sq) begin
			it_q <= it_q + 1'b1;
			if (sq[61]) begin
				y_q <= sq[62:31];
				frac_q <= {frac_q[14:0], 1'b1};
			end else begin
				y_q <= sq[61:30];
				frac_q <= {frac_q[14:0], 1'b0};
			end
		end
		if (cmd.log_mul) begin
			lnv_q <= l2[22] ? -VW'(lnprod[55:32]) : VW'(lnprod[55:32]);
			div_on_q <= 1'b1;
		end
		// divisor is the slope magnitude in both linear modes
		if (cmd.div_set) begin
			if (log_m) num_q <= ln_num;
			div_on_q <= div_on_q && (log_m ? ((ln_num != '0) && (slope != '0)
				&& (ln_num[25] == slope[VW-1])) : div_need);
			rem_q <= '0;
			quo_q <= log_m ? {(ln_num[25] ? 26'(-ln_num) : 26'(ln_num)), 16'd0} : div_num;
			dvs_q <= div_den;
			dcnt_q <= 6'd41;
		end
		if (cmd.div_step) begin
			dcnt_q <= dcnt_q - 1'b1;
			if ({rem_q[40:0], quo_q[41]} >= {1'b0, dvs_q}) begin
				rem_q <= {rem_q[40:0], quo_q[41]} - {1'b0, dvs_q};
				quo_q <= {quo_q[40:0], 1'b1};
			end else begin
				rem_q <= {rem_q[40:0], quo_q[41]};
				quo_q <= {quo_q[40:0], 1'b0};
			end
		end
	end

	logic signed [VW-1:0] fin;
	logic [41:0] qf;
	always_comb begin
		fin = res_q;
		qf = quo_q;
		if (div_on_q) begin
			if (mode == MODE_MAP) begin
				fin = map_neg ? res_q - VW'(qf) : res_q + VW'(qf);
			end else begin
				fin = (qf > 42'd65536) ? Q_ONE : VW'(qf);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.finish) begin
			out_valid <= 1'b1;
		end else if (out_take) begin
			out_valid <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			converted_value <= avail_q ? fin : '0;
			is_last <= avail_q && last_q;
			not_ready <= !avail_q;
			overflowed <= ovf_q;
			mode_ok <= (mode <= 3'd4) && !((lin_m || log_m) && slope == '0);
		end
	end
endmodule
